[sv/canonical_line_input_buffer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the line input buffer
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_LINE_INPUT_BUFFER_MACROS_SVH
`define CANONICAL_LINE_INPUT_BUFFER_MACROS_SVH
`ifndef SYNTH
// expression must never be true
`define CLIB_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("assertion failed: condition must not hold");
// antecedent implies consequent in the same cycle
`define CLIB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
`else
`define CLIB_ASSERT_NEVER(label, expr)
`define CLIB_ASSERT_IMPL(label, ante, cons)
`endif
`endif

[sv/clib_pkg.sv]
// ----------------------------------------------------------------------------
// clib_pkg
// Shared types, codes and constants of the line input buffer.
// ----------------------------------------------------------------------------
package clib_pkg;

    // defaults for the top-level parameters
    localparam int unsigned RING_DEPTH_DEF = 512;
    localparam int unsigned MAX_READ_DEF   = 64;

    // fixed field widths
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned LINES_W   = 9;
    localparam int unsigned CFG_IDX_W = 1;

    // character constants
    localparam logic [CODE_W-1:0]  NEWLINE_BYTE  = 8'h0A;
    localparam logic [CODE_W-1:0]  PRINT_LO      = 8'h20;
    localparam logic [CODE_W-1:0]  PRINT_HI      = 8'h7E;
    localparam logic [CODE_W-1:0]  ENTER_RST     = 8'd10;
    localparam logic [CODE_W-1:0]  BACKSPACE_RST = 8'd8;
    localparam logic [LINES_W-1:0] LINES_MAX     = 9'd511;

    // input operation codes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE = 1'b1;

    // classified command, front to back
    typedef enum logic [2:0] {
        CMD_IGNORE    = 3'd0,
        CMD_PRINT     = 3'd1,
        CMD_ENTER     = 3'd2,
        CMD_BACKSPACE = 3'd3,
        CMD_READ_ZERO = 3'd4,
        CMD_READ      = 3'd5
    } t_cmd_op;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_EMPTY  = 2'd2,
        KIND_NOLINE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ECHO_NONE    = 2'd0,
        ECHO_CHAR    = 2'd1,
        ECHO_NEWLINE = 2'd2,
        ECHO_ERASE   = 2'd3
    } t_echo;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_BS_CHECK = 2'd1,
        ST_RD_EMIT  = 2'd2
    } t_state;

    typedef struct packed {
        t_cmd_op           op;
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  count;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        t_echo              echo;
        logic [CODE_W-1:0]  data;
        logic               last;
        logic [LINES_W-1:0] lines;
    } t_result;

endpackage

[sv/clib_fifo.sv]
// ----------------------------------------------------------------------------
// clib_fifo
// Small register FIFO with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module clib_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/clib_front.sv]
// ----------------------------------------------------------------------------
// clib_front
// Holds the key-code registers, classifies input items into commands and
// queues them for the back end.
// ----------------------------------------------------------------------------
module clib_front #(
    parameter int unsigned MAX_READ = clib_pkg::MAX_READ_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [clib_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [clib_pkg::CODE_W-1:0]    i_cfg_data,
    // input items
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_operation,
    input  logic                           i_key_pressed,
    input  logic [clib_pkg::CODE_W-1:0]    i_key_code,
    input  logic [clib_pkg::CNT_W-1:0]     i_read_count,
    // commands to back end
    output logic                           o_cmd_valid,
    input  logic                           i_cmd_pop,
    output clib_pkg::t_cmd                 o_cmd
);
    import clib_pkg::*;

    localparam logic [CNT_W-1:0] READ_LIMIT = CNT_W'(MAX_READ);
    localparam int unsigned      CMD_W      = $bits(t_cmd);

    logic [CODE_W-1:0] r_enter_code;
    logic [CODE_W-1:0] r_backspace_code;
    t_cmd              w_cmd;
    logic [CMD_W-1:0]  w_cmd_in;
    logic [CMD_W-1:0]  w_cmd_out;
    logic              w_empty;

    // key-code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_code     <= ENTER_RST;
            r_backspace_code <= BACKSPACE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENTER:     r_enter_code     <= i_cfg_data;
                CFG_BACKSPACE: r_backspace_code <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // classification; enter takes priority over backspace and printable
    always_comb begin
        w_cmd.code  = i_key_code;
        w_cmd.count = (i_read_count > READ_LIMIT) ? READ_LIMIT : i_read_count;
        priority if (i_operation == OP_READ) begin
            w_cmd.op = (i_read_count == '0) ? CMD_READ_ZERO : CMD_READ;
        end else if (!i_key_pressed) begin
            w_cmd.op = CMD_IGNORE;
        end else if (i_key_code == r_enter_code) begin
            w_cmd.op = CMD_ENTER;
        end else if (i_key_code == r_backspace_code) begin
            w_cmd.op = CMD_BACKSPACE;
        end else if ((i_key_code >= PRINT_LO) && (i_key_code <= PRINT_HI)) begin
            w_cmd.op = CMD_PRINT;
        end else begin
            w_cmd.op = CMD_IGNORE;
        end
    end

    // command queue
    assign w_cmd_in = w_cmd;

    clib_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_data  (w_cmd_in),
        .i_pop   (i_cmd_pop),
        .o_empty (w_empty),
        .o_data  (w_cmd_out)
    );

    assign o_cmd_valid = !w_empty;
    assign o_cmd       = t_cmd'(w_cmd_out);

endmodule

[sv/clib_back.sv]
// ----------------------------------------------------------------------------
// clib_back
// Carries out commands: owns the character ring, its pointers and the line
// count, and streams read bytes out of the ring.
// ----------------------------------------------------------------------------
`include "canonical_line_input_buffer_macros.svh"

module clib_back #(
    parameter int unsigned RING_DEPTH = clib_pkg::RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    input  clib_pkg::t_cmd    i_cmd,
    input  logic              i_res_full,
    output logic              o_res_push,
    output clib_pkg::t_result o_res
);
    import clib_pkg::*;

    localparam int unsigned PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        ring_prev = (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    logic [CODE_W-1:0]  r_ring [RING_DEPTH];
    logic [CODE_W-1:0]  r_rd_data;
    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [LINES_W-1:0] r_lines, n_lines;
    logic [CNT_W-1:0]   r_left, n_left;

    logic               w_take;
    logic               w_ring_empty;
    logic               w_ring_full;
    logic [PTR_W-1:0]   w_rp_next;
    logic               w_rd_nl;
    logic               w_rd_fin;
    logic               w_mem_we;
    logic [CODE_W-1:0]  w_mem_wdata;
    logic               w_rd_en;
    logic [PTR_W-1:0]   w_rd_addr;

    // shared decode
    assign w_take       = (r_state == ST_IDLE) && i_cmd_valid && !i_res_full;
    assign w_ring_empty = (r_wp == r_rp);
    assign w_ring_full  = (ring_next(r_wp) == r_rp);
    assign w_rp_next    = ring_next(r_rp);
    assign w_rd_nl      = (r_rd_data == NEWLINE_BYTE);
    assign w_rd_fin     = w_rd_nl || (r_left == CNT_W'(1)) || (w_rp_next == r_wp);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && !w_ring_empty) begin
                    if (i_cmd.op == CMD_BACKSPACE) begin
                        n_state = ST_BS_CHECK;
                    end else if ((i_cmd.op == CMD_READ) && (r_lines != '0)) begin
                        n_state = ST_RD_EMIT;
                    end
                end
            end
            ST_BS_CHECK: begin
                if (!i_res_full) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_EMIT: begin
                if (!i_res_full && w_rd_fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res.kind  = KIND_KEY;
        o_res.echo  = ECHO_NONE;
        o_res.data  = '0;
        o_res.last  = 1'b1;
        w_mem_we    = 1'b0;
        w_mem_wdata = i_cmd.code;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_rp;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_lines     = r_lines;
        n_left      = r_left;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        CMD_PRINT: begin
                            o_res_push = 1'b1;
                            o_res.echo = ECHO_CHAR;
                            o_res.data = i_cmd.code;
                            if (!w_ring_full) begin
                                w_mem_we = 1'b1;
                                n_wp     = ring_next(r_wp);
                            end
                        end
                        CMD_ENTER: begin
                            o_res_push  = 1'b1;
                            o_res.echo  = ECHO_NEWLINE;
                            o_res.data  = NEWLINE_BYTE;
                            w_mem_wdata = NEWLINE_BYTE;
                            // a dropped newline does not count as a line
                            if (!w_ring_full) begin
                                w_mem_we = 1'b1;
                                n_wp     = ring_next(r_wp);
                                if (r_lines != LINES_MAX) begin
                                    n_lines = r_lines + 1'b1;
                                end
                            end
                        end
                        CMD_BACKSPACE: begin
                            if (w_ring_empty) begin
                                o_res_push = 1'b1;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = ring_prev(r_wp);
                            end
                        end
                        CMD_READ_ZERO: begin
                            o_res_push = 1'b1;
                            o_res.kind = KIND_EMPTY;
                        end
                        CMD_READ: begin
                            if (r_lines == '0) begin
                                o_res_push = 1'b1;
                                o_res.kind = KIND_NOLINE;
                            end else if (w_ring_empty) begin
                                o_res_push = 1'b1;
                                o_res.kind = KIND_EMPTY;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_rp;
                                n_left    = i_cmd.count;
                            end
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_BS_CHECK: begin
                // erase only if the last character does not end a line
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (!w_rd_nl) begin
                        o_res.echo = ECHO_ERASE;
                        n_wp       = ring_prev(r_wp);
                    end
                end
            end
            ST_RD_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res.kind = KIND_BYTE;
                    o_res.data = r_rd_data;
                    o_res.last = w_rd_fin;
                    n_rp       = w_rp_next;
                    n_left     = r_left - 1'b1;
                    if (w_rd_nl && (r_lines != '0)) begin
                        n_lines = r_lines - 1'b1;
                    end
                    // fetch the following byte while this one is sent
                    if (!w_rd_fin) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_rp_next;
                    end
                end
            end
            default: ;
        endcase
        o_res.lines = n_lines;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_lines <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_lines <= n_lines;
            r_left  <= n_left;
        end
    end

    // character ring, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_ring[r_wp] <= w_mem_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_ring[w_rd_addr];
        end
    end

    // checks
    `CLIB_ASSERT_NEVER(a_ring_overrun, w_mem_we && (ring_next(r_wp) == r_rp))
    `CLIB_ASSERT_NEVER(a_res_overflow, o_res_push && i_res_full)
    `CLIB_ASSERT_NEVER(a_read_past_write, (r_state == ST_RD_EMIT) && (r_rp == r_wp))
    `CLIB_ASSERT_IMPL(a_bs_entry, (r_state == ST_BS_CHECK) && ($past(r_state) == ST_IDLE), $past(o_cmd_pop))

endmodule

[sv/canonical_line_input_buffer.sv]
// ----------------------------------------------------------------------------
// canonical_line_input_buffer
// Keyboard line-editing ring buffer with line counting and line reads.
// ----------------------------------------------------------------------------
// Input items are transferred with push/full, results with empty/pop; both
// sides behave as queues. Key codes for enter and backspace are written on
// the plain write port (index 0 enter, index 1 backspace) by the user, only
// while idle; the block does not enforce it. A key event gives one result;
// a read request gives one result per byte read, or a single empty / no-line
// result. The final result carries last. A result passes through the command
// queue and the result queue; a backspace or the first byte of a read also
// goes through the registered ring read port. One key event is taken per
// cycle while the result queue has room, a backspace holding the back end in
// a check state; a read request takes a set-up step, then streams one byte
// per cycle on that condition, set by the single registered ring read port.
// Reset clears pointers, line count and queues and presets the key-code
// registers; the ring stays undefined until written, with no clearing pass.
// If the receiver stops popping, the result queue fills, the back end holds,
// then the command queue fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module canonical_line_input_buffer #(
    parameter int unsigned RING_DEPTH = clib_pkg::RING_DEPTH_DEF,
    parameter int unsigned MAX_READ   = clib_pkg::MAX_READ_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [clib_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [clib_pkg::CODE_W-1:0]    i_cfg_data,
    // input items
    input  logic                           push,
    output logic                           full,
    input  logic                           i_operation,
    input  logic                           i_key_pressed,
    input  logic [clib_pkg::CODE_W-1:0]    i_key_code,
    input  logic [clib_pkg::CNT_W-1:0]     i_read_count,
    // results
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     o_result_kind,
    output logic [1:0]                     o_echo_action,
    output logic [clib_pkg::CODE_W-1:0]    o_data_byte,
    output logic                           o_last,
    output logic [clib_pkg::LINES_W-1:0]   o_lines_waiting
);
    import clib_pkg::*;

    localparam int unsigned RES_W = $bits(t_result);

    logic             w_cmd_valid;
    logic             w_cmd_pop;
    t_cmd             w_cmd;
    logic             w_res_full;
    logic             w_res_push;
    t_result          w_res;
    logic [RES_W-1:0] w_res_in;
    logic [RES_W-1:0] w_res_out;
    t_result          w_res_head;

    // front end: configuration, classification, command queue
    clib_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .o_full        (full),
        .i_operation   (i_operation),
        .i_key_pressed (i_key_pressed),
        .i_key_code    (i_key_code),
        .i_read_count  (i_read_count),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_pop     (w_cmd_pop),
        .o_cmd         (w_cmd)
    );

    // back end: ring and line bookkeeping
    clib_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // result queue
    assign w_res_in = w_res;

    clib_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .o_full  (w_res_full),
        .i_data  (w_res_in),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_out)
    );

    assign w_res_head      = t_result'(w_res_out);
    assign o_result_kind   = w_res_head.kind;
    assign o_echo_action   = w_res_head.echo;
    assign o_data_byte     = w_res_head.data;
    assign o_last          = w_res_head.last;
    assign o_lines_waiting = w_res_head.lines;

endmodule

[sim/canonical_line_input_buffer_tb.sv]
// ----------------------------------------------------------------------------
// canonical_line_input_buffer_tb
// Self-checking bench for the keyboard line-editing buffer. A directed table
// covers key handling, reads and register settings first. Random editing
// sessions follow under several key-code settings, including a stretch where
// the result side is held off until the input stalls. Every result is
// checked against a typed-in value or the behavioural line-discipline model.
// ----------------------------------------------------------------------------
module canonical_line_input_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clib_pkg::*;

    localparam int RING_N        = RING_DEPTH_DEF;
    localparam int MAX_RD        = MAX_READ_DEF;
    localparam int HOLD_CYCLES   = 400;
    localparam int HANG_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int NUM_DIR       = 30;
    localparam int MAX_PRINTED   = 40;
    localparam int FLOOD_KEYS    = 20;

    // one row of the directed table: a register write or an input item
    typedef struct {
        logic                 cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic                 op;
        logic                 pressed;
        logic [CODE_W-1:0]    code;
        logic [CNT_W-1:0]     count;
        logic                 typed;
        t_kind                kind;
        t_echo                echo;
        logic [CODE_W-1:0]    data;
        logic [LINES_W-1:0]   lines;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CODE_W-1:0]    i_cfg_data;
    logic                 push;
    logic                 full;
    logic                 i_operation;
    logic                 i_key_pressed;
    logic [CODE_W-1:0]    i_key_code;
    logic [CNT_W-1:0]     i_read_count;
    logic                 empty;
    logic                 pop;
    logic [1:0]           o_result_kind;
    logic [1:0]           o_echo_action;
    logic [CODE_W-1:0]    o_data_byte;
    logic                 o_last;
    logic [LINES_W-1:0]   o_lines_waiting;

    // model of the line discipline
    logic [CODE_W-1:0] line_ring [RING_N];
    int                wr_ptr;
    int                rd_ptr;
    int                line_count;
    logic [CODE_W-1:0] enter_key;
    logic [CODE_W-1:0] erase_key;
    t_result           step_out [$];
    t_result           results_due [$];

    // run bookkeeping
    int mismatches     = 0;
    int items_sent     = 0;
    int reads_sent     = 0;
    int results_seen   = 0;
    int ring_full_hits = 0;
    int cfg_writes     = 0;
    int tx_run         = 0;
    int rx_run         = 0;
    bit hold_request   = 1'b0;
    bit sender_fast    = 1'b0;

    // directed table; expected result typed in where it is plain to see
    t_dir_row directed_rows [NUM_DIR] = '{
        // key release of the enter code: nothing happens
        '{1'b0, CFG_ENTER, OP_KEY, 1'b0, 8'h0A, 7'd0, 1'b1, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        // backspace on an empty ring
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h08, 7'd0, 1'b1, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        // read with no complete line
        '{1'b0, CFG_ENTER, OP_READ, 1'b0, 8'h00, 7'd5, 1'b1, KIND_NOLINE, ECHO_NONE, 8'h00, 9'd0},
        // zero-count read wins even with no line
        '{1'b0, CFG_ENTER, OP_READ, 1'b0, 8'h00, 7'd0, 1'b1, KIND_EMPTY, ECHO_NONE, 8'h00, 9'd0},
        // printable range edges, then codes just outside it
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h20, 7'd0, 1'b1, KIND_KEY, ECHO_CHAR, 8'h20, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h7E, 7'd0, 1'b1, KIND_KEY, ECHO_CHAR, 8'h7E, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h1F, 7'd0, 1'b1, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h7F, 7'd0, 1'b1, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        // erase, line end, then backspace refused behind the newline
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h08, 7'd0, 1'b1, KIND_KEY, ECHO_ERASE, 8'h00, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h0A, 7'd0, 1'b1, KIND_KEY, ECHO_NEWLINE, 8'h0A, 9'd1},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h08, 7'd0, 1'b1, KIND_KEY, ECHO_NONE, 8'h00, 9'd1},
        '{1'b0, CFG_ENTER, OP_READ, 1'b1, 8'hFF, 7'd0, 1'b1, KIND_EMPTY, ECHO_NONE, 8'h00, 9'd1},
        // count above the maximum saturates
        '{1'b0, CFG_ENTER, OP_READ, 1'b0, 8'h00, 7'd127, 1'b0, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h48, 7'd0, 1'b1, KIND_KEY, ECHO_CHAR, 8'h48, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h69, 7'd0, 1'b1, KIND_KEY, ECHO_CHAR, 8'h69, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h0A, 7'd0, 1'b1, KIND_KEY, ECHO_NEWLINE, 8'h0A, 9'd1},
        // partial read stops on the count, the next one on the newline
        '{1'b0, CFG_ENTER, OP_READ, 1'b0, 8'h00, 7'd1, 1'b0, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        '{1'b0, CFG_ENTER, OP_READ, 1'b0, 8'h00, 7'd64, 1'b0, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        // enter and backspace share a printable code: enter wins
        '{1'b1, CFG_ENTER, OP_KEY, 1'b0, 8'h41, 7'd0, 1'b0, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        '{1'b1, CFG_BACKSPACE, OP_KEY, 1'b0, 8'h41, 7'd0, 1'b0, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h41, 7'd0, 1'b1, KIND_KEY, ECHO_NEWLINE, 8'h0A, 9'd1},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h0A, 7'd0, 1'b1, KIND_KEY, ECHO_NONE, 8'h00, 9'd1},
        '{1'b0, CFG_ENTER, OP_READ, 1'b0, 8'h00, 7'd64, 1'b0, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        // extreme codes: enter 0x00, backspace 0xFF
        '{1'b1, CFG_ENTER, OP_KEY, 1'b0, 8'h00, 7'd0, 1'b0, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        '{1'b1, CFG_BACKSPACE, OP_KEY, 1'b0, 8'hFF, 7'd0, 1'b0, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'hFF, 7'd0, 1'b1, KIND_KEY, ECHO_NONE, 8'h00, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h7E, 7'd0, 1'b1, KIND_KEY, ECHO_CHAR, 8'h7E, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'hFF, 7'd0, 1'b1, KIND_KEY, ECHO_ERASE, 8'h00, 9'd0},
        '{1'b0, CFG_ENTER, OP_KEY, 1'b1, 8'h00, 7'd0, 1'b1, KIND_KEY, ECHO_NEWLINE, 8'h0A, 9'd1},
        '{1'b0, CFG_ENTER, OP_READ, 1'b0, 8'h00, 7'd64, 1'b0, KIND_KEY, ECHO_NONE, 8'h00, 9'd0}
    };

    canonical_line_input_buffer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_key_pressed  (i_key_pressed),
        .i_key_code     (i_key_code),
        .i_read_count   (i_read_count),
        .empty          (empty),
        .pop            (pop),
        .o_result_kind  (o_result_kind),
        .o_echo_action  (o_echo_action),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last),
        .o_lines_waiting(o_lines_waiting)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic int ring_after(input int p);
        return (p + 1) % RING_N;
    endfunction

    // store one character; refused when only one slot is left
    function automatic bit ring_store(input logic [CODE_W-1:0] ch);
        if (ring_after(wr_ptr) == rd_ptr) begin
            ring_full_hits++;
            return 1'b0;
        end
        line_ring[wr_ptr] = ch;
        wr_ptr = ring_after(wr_ptr);
        return 1'b1;
    endfunction

    // results of one input item, left in step_out
    task automatic line_discipline_step(input logic op, input logic pressed,
                                        input logic [CODE_W-1:0] code,
                                        input logic [CNT_W-1:0] count);
        t_result r;
        int      lim;
        int      n;
        int      back;
        bit      stored;
        bit      nl;
        step_out.delete();
        r = '{kind: KIND_KEY, echo: ECHO_NONE, data: '0, last: 1'b1, lines: '0};
        if (op == OP_KEY) begin
            if (pressed) begin
                if (code == enter_key) begin
                    stored = ring_store(NEWLINE_BYTE);
                    if (stored && line_count < int'(LINES_MAX))
                        line_count++;
                    r.echo = ECHO_NEWLINE;
                    r.data = NEWLINE_BYTE;
                end else if (code == erase_key) begin
                    back = (wr_ptr + RING_N - 1) % RING_N;
                    if (wr_ptr != rd_ptr && line_ring[back] != NEWLINE_BYTE) begin
                        wr_ptr = back;
                        r.echo = ECHO_ERASE;
                    end
                end else if (code >= PRINT_LO && code <= PRINT_HI) begin
                    void'(ring_store(code));
                    r.echo = ECHO_CHAR;
                    r.data = code;
                end
            end
            r.lines = LINES_W'(line_count);
            step_out.push_back(r);
        end else if (count == 0) begin
            r.kind  = KIND_EMPTY;
            r.lines = LINES_W'(line_count);
            step_out.push_back(r);
        end else if (line_count == 0) begin
            r.kind = KIND_NOLINE;
            step_out.push_back(r);
        end else begin
            lim = (int'(count) > MAX_RD) ? MAX_RD : int'(count);
            n   = 0;
            nl  = 1'b0;
            // stream bytes through the first newline or up to the count
            while (n < lim && rd_ptr != wr_ptr && !nl) begin
                r.kind = KIND_BYTE;
                r.data = line_ring[rd_ptr];
                rd_ptr = ring_after(rd_ptr);
                nl     = (r.data == NEWLINE_BYTE);
                if (nl && line_count > 0)
                    line_count--;
                r.last  = nl || (n + 1 == lim) || (rd_ptr == wr_ptr);
                r.lines = LINES_W'(line_count);
                step_out.push_back(r);
                n++;
            end
            if (n == 0) begin
                r.kind  = KIND_EMPTY;
                r.lines = LINES_W'(line_count);
                step_out.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // wait before the next transfer: mostly random, sometimes a run of zeros
    task automatic draw_wait(inout int run_left, output int w);
        if (run_left > 0) begin
            run_left--;
            w = 0;
        end else if ($urandom_range(0, 11) == 0) begin
            run_left = $urandom_range(8, 30);
            w = 0;
        end else begin
            w = $urandom_range(0, 18);
        end
    endtask

    // offer one item, wait for its transfer, then predict its results
    task automatic send_item(input logic op, input logic pressed,
                             input logic [CODE_W-1:0] code,
                             input logic [CNT_W-1:0] count,
                             input bit typed_on, input t_result typed);
        int w;
        draw_wait(tx_run, w);
        if (sender_fast)
            w = 0;
        if (w != 0) begin
            push <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_operation   <= op;
        i_key_pressed <= pressed;
        i_key_code    <= code;
        i_read_count  <= count;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        line_discipline_step(op, pressed, code, count);
        if (typed_on)
            results_due.push_back(typed);
        else
            foreach (step_out[k]) results_due.push_back(step_out[k]);
        items_sent++;
        if (op == OP_READ)
            reads_sent++;
    endtask

    task automatic send_key(input logic pressed, input logic [CODE_W-1:0] code);
        send_item(OP_KEY, pressed, code, CNT_W'($urandom), 1'b0, '0);
    endtask

    task automatic send_read(input logic [CNT_W-1:0] count);
        send_item(OP_READ, 1'($urandom), CODE_W'($urandom), count, 1'b0, '0);
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return CNT_W'($urandom_range(MAX_RD + 1, 127));
            3, 4, 5: return CNT_W'($urandom_range(1, 20));
            default: return CNT_W'(MAX_RD);
        endcase
    endfunction

    // drop the input side and let the block drain before a register write
    task automatic wait_idle();
        push <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ENTER)
            enter_key = val;
        else
            erase_key = val;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_keys(input logic [CODE_W-1:0] enter_v, input logic [CODE_W-1:0] erase_v);
        wait_idle();
        write_reg(CFG_ENTER, enter_v);
        write_reg(CFG_BACKSPACE, erase_v);
    endtask

    // one typed line with occasional edits and noise, closed by enter
    task automatic type_line(input int len);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 19))
                0, 1:    send_key(1'b1, erase_key);
                2:       send_key(1'b0, CODE_W'($urandom));
                3:       send_key(1'b1, CODE_W'($urandom));
                default: send_key(1'b1, CODE_W'($urandom_range(PRINT_LO, PRINT_HI)));
            endcase
        end
        send_key(1'b1, enter_key);
    endtask

    // random editing session: mostly lines followed by reads
    task automatic run_session(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target) begin
            case ($urandom_range(0, 9))
                0: send_item(1'($urandom), 1'($urandom), CODE_W'($urandom),
                             CNT_W'($urandom), 1'b0, '0);
                1: send_read(pick_count());
                default: begin
                    type_line(($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(0, 12));
                    if ($urandom_range(0, 3) != 0)
                        send_read(pick_count());
                end
            endcase
        end
    endtask

    // keep keys coming with the result side held off, so both queues fill and
    // the input stalls; then read back what was typed
    task automatic flood_and_drain();
        hold_request = 1'b1;
        sender_fast  = 1'b1;
        for (int i = 0; i < FLOOD_KEYS; i++) begin
            if ($urandom_range(0, 5) == 0)
                send_key(1'b1, enter_key);
            else
                send_key(1'b1, CODE_W'($urandom_range(PRINT_LO, PRINT_HI)));
        end
        send_key(1'b1, erase_key);
        send_key(1'b1, enter_key);
        sender_fast = 1'b0;
        while (line_count > 0)
            send_read(($urandom_range(0, 3) == 0) ? pick_count() : CNT_W'(MAX_RD));
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // result side: random pop stalls, one long hold-off on request
    initial begin : result_sink
        int      w;
        t_result got;
        t_result want;
        pop <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            draw_wait(rx_run, w);
            if (hold_request) begin
                hold_request = 1'b0;
                w = HOLD_CYCLES;
            end
            if (w != 0) begin
                pop <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty !== 1'b0) @(posedge i_clk);
            results_seen++;
            got.kind  = t_kind'(o_result_kind);
            got.echo  = t_echo'(o_echo_action);
            got.data  = o_data_byte;
            got.last  = o_last;
            got.lines = o_lines_waiting;
            if (results_due.size() == 0) begin
                flag_mismatch($sformatf("result %0d with nothing outstanding: kind %0d data %02h",
                                        results_seen, got.kind, got.data));
            end else begin
                want = results_due.pop_front();
                if (got.kind !== want.kind || got.echo !== want.echo ||
                    got.data !== want.data || got.last !== want.last ||
                    got.lines !== want.lines)
                    flag_mismatch($sformatf(
                        "result %0d: kind %0d/%0d echo %0d/%0d data %02h/%02h last %0b/%0b lines %0d/%0d",
                        results_seen, got.kind, want.kind, got.echo, want.echo,
                        got.data, want.data, got.last, want.last, got.lines, want.lines));
            end
        end
    end

    // watchdog: ends the run when no transfer happens for too long
    initial begin : hang_watch
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no transfer for %0d cycles", $realtime, HANG_LIMIT);
        $display("canonical_line_input_buffer_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_result fixed;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_ENTER;
        i_cfg_data    <= '0;
        push          <= 1'b0;
        i_operation   <= OP_KEY;
        i_key_pressed <= 1'b0;
        i_key_code    <= '0;
        i_read_count  <= '0;
        wr_ptr     = 0;
        rd_ptr     = 0;
        line_count = 0;
        enter_key  = ENTER_RST;
        erase_key  = BACKSPACE_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg) begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].code);
            end else begin
                fixed = '{kind: directed_rows[i].kind, echo: directed_rows[i].echo,
                          data: directed_rows[i].data, last: 1'b1,
                          lines: directed_rows[i].lines};
                send_item(directed_rows[i].op, directed_rows[i].pressed,
                          directed_rows[i].code, directed_rows[i].count,
                          directed_rows[i].typed, fixed);
            end
        end

        // random sessions under a spread of key-code settings
        set_keys(ENTER_RST, BACKSPACE_RST);
        flood_and_drain();
        run_session(30);
        set_keys(8'hFF, 8'h00);
        run_session(30);
        set_keys(PRINT_LO, PRINT_HI);
        run_session(30);
        set_keys(CODE_W'($urandom), CODE_W'($urandom));
        run_session(30);
        set_keys(ENTER_RST, BACKSPACE_RST);
        run_session(30);

        // wind down
        push <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (results_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", results_due.size()));

        $display("Run: %0d input items (%0d reads), %0d results, %0d register writes.",
                 items_sent, reads_sent, results_seen, cfg_writes);
        $display("Keys refused by a full ring: %0d; result side held off for %0d cycles once.",
                 ring_full_hits, HOLD_CYCLES);
        if (mismatches == 0)
            $display("canonical_line_input_buffer_tb: PASS");
        else
            $display("canonical_line_input_buffer_tb: FAIL");
        $finish;
    end

endmodule
